// ===== sv/v3n_pkg.sv =====
// Shared types for the vector3_normalize block.
package v3n_pkg;

	// Control that each division lane receives with its operands
	typedef struct packed {
		logic adv;  // pipeline advance
		logic neg;  // sign of the component entering the lane
	} lane_ctl_t;

endpackage

// ===== sv/v3n_unit_lane.sv =====
// One component lane: bit-serial pipelined quotient c / sqrt(S) in Q1.F.
module v3n_unit_lane #(
	parameter int W   = 16,
	parameter int F   = 14,
	parameter int NST = 16
) (
	input  logic                  clk,
	input  v3n_pkg::lane_ctl_t    ctl,
	input  logic [2*W-1:0]        sq,
	input  logic [2*W-1:0]        sum,
	output logic signed [F+1:0]   unit
);

	localparam int SW = 2 * W;
	localparam int QW = F + 1;
	localparam int PW = SW + F + 1;
	localparam int DW = SW + 2 * F + 3;

	logic [DW-1:0] rem_s [0:NST];
	logic [PW-1:0] p_s   [0:NST];
	logic [QW-1:0] q_s   [0:NST];
	logic [SW-1:0] sum_s [0:NST];
	logic          neg_s [0:NST];

	// Seed: remainder c^2 * 2^(2F), empty quotient
	always_comb begin
		rem_s[0] = {{(DW-SW){1'b0}}, sq} << (2 * F);
		p_s[0]   = '0;
		q_s[0]   = '0;
		sum_s[0] = sum;
		neg_s[0] = ctl.neg;
	end

	for (genvar k = 0; k < NST; k++) begin : g_step
		if (k <= F) begin : g_bit
			localparam int B = F - k;
			logic [DW-1:0] d;
			logic          take;

			// Growth of q^2*S when bit B is set: 2^(B+1)*q*S + 2^(2B)*S
			always_comb begin
				d    = ({{(DW-PW){1'b0}}, p_s[k]} << (B + 1))
				     + ({{(DW-SW){1'b0}}, sum_s[k]} << (2 * B));
				take = (d <= rem_s[k]);
			end

			always_ff @(posedge clk) begin
				if (ctl.adv) begin
					rem_s[k+1] <= take ? rem_s[k] - d : rem_s[k];
					q_s[k+1]   <= take ? q_s[k] | (QW'(1) << B) : q_s[k];
					p_s[k+1]   <= take ? p_s[k] + ({{(PW-SW){1'b0}}, sum_s[k]} << B)
					                   : p_s[k];
					sum_s[k+1] <= sum_s[k];
					neg_s[k+1] <= neg_s[k];
				end
			end
		end else begin : g_pass
			// Hold alignment with the longer square-root chain
			always_ff @(posedge clk) begin
				if (ctl.adv) begin
					rem_s[k+1] <= rem_s[k];
					q_s[k+1]   <= q_s[k];
					p_s[k+1]   <= p_s[k];
					sum_s[k+1] <= sum_s[k];
					neg_s[k+1] <= neg_s[k];
				end
			end
		end
	end

	// Apply the sign of the component
	assign unit = neg_s[NST] ? -$signed({1'b0, q_s[NST]}) : $signed({1'b0, q_s[NST]});

endmodule

// ===== sv/vector3_normalize.sv =====
// Throughput: one vector per cycle unless the output stalls; each result bit of the square
// root and of the three quotients is settled by its own pipeline stage.
// A stall on the output side holds every stage in place.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
// Top level: length and unit vector of a 3D Q8.8 vector.
module vector3_normalize #(
	parameter int IN_WIDTH      = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// comp_x, comp_y, comp_z (IN_WIDTH each), zero fill to bytes
	input  logic [((3*IN_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// magnitude (IN_WIDTH), unit_x, unit_y, unit_z (OUT_FRAC_BITS+2 each), zero fill
	output logic [((IN_WIDTH+3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
	// zero_length
	output logic m_tuser
);

	localparam int W    = IN_WIDTH;
	localparam int F    = OUT_FRAC_BITS;
	localparam int UW   = F + 2;
	localparam int SW   = 2 * W;
	localparam int NST  = (W > F + 1) ? W : F + 1;
	localparam int OW   = W + 3 * UW;
	localparam int OPAD = ((OW + 7) / 8) * 8;

	logic adv;
	logic out_vld_q;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	// Stage 1: magnitudes and signs
	logic [W-1:0]  abs_s1 [0:2];
	logic          neg_s1 [0:2];
	logic [SW-1:0] sq_s2  [0:2];
	logic          neg_s2 [0:2];
	logic [SW-1:0] sq_s3  [0:2];
	logic          neg_s3 [0:2];
	logic [SW-1:0] sum_s3;
	logic          vld_s1, vld_s2, vld_s3;

	for (genvar i = 0; i < 3; i++) begin : g_in
		logic [W-1:0] raw;
		assign raw = s_tdata[i*W +: W];
		always_ff @(posedge clk) begin
			if (adv) begin
				abs_s1[i] <= raw[W-1] ? ~raw + W'(1) : raw;
				neg_s1[i] <= raw[W-1];
				sq_s2[i]  <= SW'(abs_s1[i]) * SW'(abs_s1[i]);
				neg_s2[i] <= neg_s1[i];
				sq_s3[i]  <= sq_s2[i];
				neg_s3[i] <= neg_s2[i];
			end
		end
	end

	// Stage 3: sum of squares (fits 2*IN_WIDTH bits)
	always_ff @(posedge clk) begin
		if (adv) sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	// Advance the valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Square-root chain: one result bit per stage, padded with pass stages to the lane depth
	logic [SW:0]   rem_p [0:NST];
	logic [W-1:0]  rt_p  [0:NST];
	logic          zero_p[0:NST];
	logic          vld_p [0:NST];

	always_comb begin
		rem_p[0]  = {1'b0, sum_s3};
		rt_p[0]   = '0;
		zero_p[0] = (sum_s3 == '0);
		vld_p[0]  = vld_s3;
	end

	for (genvar k = 0; k < NST; k++) begin : g_sqrt
		if (k < W) begin : g_bit
			localparam int B = W - 1 - k;
			logic [SW:0] d;
			logic        take;
			always_comb begin
				d    = ({{(SW+1-W){1'b0}}, rt_p[k]} << (B + 1)) + ((SW+1)'(1) << (2 * B));
				take = (d <= rem_p[k]);
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_p[k+1] <= take ? rem_p[k] - d : rem_p[k];
					rt_p[k+1]  <= take ? rt_p[k] | (W'(1) << B) : rt_p[k];
					zero_p[k+1] <= zero_p[k];
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_p[k+1]  <= rem_p[k];
					rt_p[k+1]   <= rt_p[k];
					zero_p[k+1] <= zero_p[k];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[k+1] <= 1'b0;
			end else if (adv) begin
				vld_p[k+1] <= vld_p[k];
			end
		end
	end

	// Division lanes, one per component
	logic signed [UW-1:0] unit_w [0:2];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3n_pkg::lane_ctl_t ctl;
		assign ctl.adv = adv;
		assign ctl.neg = neg_s3[i];
		v3n_unit_lane #(.W(W), .F(F), .NST(NST)) u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.sq   (sq_s3[i]),
			.sum  (sum_s3),
			.unit (unit_w[i])
		);
	end

	// Output register: force units to zero for a zero vector
	logic [W-1:0]  mag_q;
	logic [UW-1:0] ux_q, uy_q, uz_q;
	logic          zero_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_q  <= rt_p[NST];
			ux_q   <= zero_p[NST] ? '0 : unit_w[0];
			uy_q   <= zero_p[NST] ? '0 : unit_w[1];
			uz_q   <= zero_p[NST] ? '0 : unit_w[2];
			zero_q <= zero_p[NST];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_p[NST];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OPAD-OW){1'b0}}, uz_q, uy_q, ux_q, mag_q};
	assign m_tuser  = zero_q;

endmodule

// ===== dv/tb_vector3_normalize.sv =====
// Self-checking testbench for vector3_normalize: directed table plus random vectors.
`timescale 1ns / 100ps

module tb_vector3_normalize;

	localparam int IW  = 16;
	localparam int FB  = 14;
	localparam int UW  = FB + 2;
	localparam int SDW = ((3*IW+7)/8)*8;
	localparam int MDW = ((IW+3*UW+7)/8)*8;
	localparam int NRAND = 2000;

	typedef struct packed {
		logic [IW-1:0] mag;
		logic [UW-1:0] ux;
		logic [UW-1:0] uy;
		logic [UW-1:0] uz;
		logic          zl;
	} norm_t;

	typedef struct {
		logic signed [IW-1:0] x, y, z;
		bit    has_fixed;
		norm_t fixed_res;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SDW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MDW-1:0] m_tdata;
	logic m_tuser;

	norm_t expected_norms[$];
	int    errors = 0;
	bit    quiet = 1'b0;
	bit    stim_done = 1'b0;
	vec_row_t rows[$];

	vector3_normalize #(.IN_WIDTH(IW), .OUT_FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("vector3_normalize test failed");
		$finish;
	end

	// Floor of integer square root
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		r = 0;
		for (int b = 17; b >= 0; b--)
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n)
				r = r | (64'd1 << b);
		return r;
	endfunction

	// Largest q <= 2^FB with q*q*s <= c*c*2^(2FB); 128-bit products
	function automatic longint unsigned unit_frac(longint unsigned c, longint unsigned s);
		logic [127:0] rhs, lhs;
		longint unsigned q, t;
		q = 0;
		rhs = 128'(c * c) << (2 * FB);
		for (int b = FB; b >= 0; b--) begin
			t = q | (64'd1 << b);
			lhs = 128'(t * t) * 128'(s);
			if (lhs <= rhs)
				q = t;
		end
		return q;
	endfunction

	function automatic norm_t predict_norm(logic signed [IW-1:0] x, y, z);
		norm_t r;
		longint unsigned c[3], s, q;
		logic signed [IW-1:0] v[3];
		v = '{x, y, z};
		s = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = v[i] < 0 ? longint'(-longint'(v[i])) : longint'(v[i]);
			s += c[i] * c[i];
		end
		r = '0;
		r.mag = IW'(int_sqrt(s));
		if (s == 0) begin
			r.zl = 1'b1;
			return r;
		end
		q = unit_frac(c[0], s); r.ux = v[0] < 0 ? UW'(-q) : UW'(q);
		q = unit_frac(c[1], s); r.uy = v[1] < 0 ? UW'(-q) : UW'(q);
		q = unit_frac(c[2], s); r.uz = v[2] < 0 ? UW'(-q) : UW'(q);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Send one request, idling at random beforehand
	task automatic send_vector(logic signed [IW-1:0] x, y, z, bit has_fixed, norm_t fr);
		norm_t e;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		e = predict_norm(x, y, z);
		if (has_fixed && e !== fr)
			report_mismatch("table vs predictor", e, fr);
		s_tvalid <= 1'b1;
		s_tdata  <= SDW'({z, y, x});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_norms.push_back(has_fixed ? fr : e);
	endtask

	function automatic logic signed [IW-1:0] rand_comp();
		case ($urandom_range(0, 4))
			0: return IW'(int'($urandom_range(0, 6)) - 3);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return IW'($urandom);
		endcase
	endfunction

	function automatic vec_row_t mk(int x, y, z, bit f, norm_t r);
		vec_row_t v;
		v.x = IW'(x); v.y = IW'(y); v.z = IW'(z); v.has_fixed = f; v.fixed_res = r;
		return v;
	endfunction

	// Stimulus
	initial begin
		norm_t nz;
		nz = '0;
		rows.push_back(mk(0, 0, 0, 1, '{mag: 0, ux: 0, uy: 0, uz: 0, zl: 1}));
		rows.push_back(mk(256, 0, 0, 1, '{mag: 256, ux: 16384, uy: 0, uz: 0, zl: 0}));
		rows.push_back(mk(0, -256, 0, 1, '{mag: 256, ux: 0, uy: -16384, uz: 0, zl: 0}));
		rows.push_back(mk(0, 0, 1, 1, '{mag: 1, ux: 0, uy: 0, uz: 16384, zl: 0}));
		rows.push_back(mk(-32768, 0, 0, 1,
			'{mag: 32768, ux: -16384, uy: 0, uz: 0, zl: 0}));
		rows.push_back(mk(-32768, -32768, -32768, 0, nz));
		rows.push_back(mk(32767, 32767, 32767, 0, nz));
		rows.push_back(mk(32767, -32768, 32767, 0, nz));
		rows.push_back(mk(1, 1, 1, 0, nz));
		rows.push_back(mk(-1, 0, 0, 0, nz));
		rows.push_back(mk(3, 4, 0, 0, nz));
		rows.push_back(mk(0, 0, 32767, 0, nz));
		rows.push_back(mk(-1, -1, -1, 0, nz));
		rows.push_back(mk(12345, -23456, 345, 0, nz));
		rows.push_back(mk(21845, -21846, 10922, 0, nz));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].has_fixed, rows[i].fixed_res);
		// Hold off until the pipeline drains
		s_tvalid <= 1'b0;
		while (expected_norms.size() != 0) @(posedge clk);
		for (int n = 0; n < NRAND; n++) begin
			if (n == NRAND - 200)
				quiet = 1'b1;
			send_vector(rand_comp(), rand_comp(), rand_comp(), 0, nz);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Output stall pattern
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Check results
	always @(posedge clk) begin
		norm_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[IW-1:0], m_tdata[IW+:UW], m_tdata[IW+UW+:UW],
				m_tdata[IW+2*UW+:UW], m_tuser};
			if (expected_norms.size() == 0) begin
				report_mismatch("unexpected result", got, 0);
			end else begin
				want = expected_norms.pop_front();
				if (got.mag !== want.mag) report_mismatch("magnitude", got.mag, want.mag);
				if (got.ux !== want.ux) report_mismatch("unit_x", got.ux, want.ux);
				if (got.uy !== want.uy) report_mismatch("unit_y", got.uy, want.uy);
				if (got.uz !== want.uz) report_mismatch("unit_z", got.uz, want.uz);
				if (got.zl !== want.zl) report_mismatch("zero_length", got.zl, want.zl);
			end
		end
	end

	// Finish after draining
	initial begin
		wait (stim_done);
		while (expected_norms.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("vector3_normalize test passed");
		else
			$display("vector3_normalize test failed");
		$finish;
	end

endmodule
